// ----- rtl/core/lgrq_pkg.sv -----
// Shared types and constants of the longest gap range query block.
// No dependencies; every other file of the block imports this package.
package lgrq_pkg;

  localparam int unsigned DEPTH_DEF       = 1024;
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  localparam int unsigned POS_W  = 10;
  localparam int unsigned END_W  = 11;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned EXT_W  = 64;
  localparam int unsigned RUN_W  = 11;
  localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } lgrq_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } lgrq_state_e;

  typedef struct packed {
    logic clear;
    logic step;
  } lgrq_scan_ctrl_t;

endpackage

// ----- rtl/core/lgrq_cell.sv -----
// One storage cell of the rotating element ring.
// Depends on lgrq_pkg for the default value width.
module lgrq_cell import lgrq_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   wr_en_i,
  input  logic [VALUE_WIDTH-1:0] wr_val_i,
  input  logic                   shift_i,
  input  logic [VALUE_WIDTH-1:0] nbr_i,
  output logic [VALUE_WIDTH-1:0] val_o
);

  logic [VALUE_WIDTH-1:0] val_q;

  // Load on a write, take the neighbour's value on a rotation step, else hold.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      val_q <= wr_val_i;
    end else if (shift_i) begin
      val_q <= nbr_i;
    end
  end

  assign val_o = val_q;

endmodule

// ----- rtl/core/lgrq_scan.sv -----
// Run tracker: consumes one element per step and keeps current and best run.
// Depends on lgrq_pkg for field widths, saturation limit and control struct.
module lgrq_scan import lgrq_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int unsigned IDX_W       = 10
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lgrq_scan_ctrl_t        ctrl_i,
  input  logic [IDX_W-1:0]       idx_i,
  input  logic [POS_W-1:0]       pos_i,
  input  logic [END_W-1:0]       end_i,
  input  logic [VALUE_WIDTH-1:0] excl_i,
  input  logic [VALUE_WIDTH-1:0] elem_i,
  output logic [RUN_W-1:0]       best_o
);

  localparam int unsigned CMP_W = (IDX_W + 1 > END_W) ? IDX_W + 1 : END_W;

  logic [RUN_W-1:0] cur_q, cur_d;
  logic [RUN_W-1:0] best_q, best_d;
  logic [RUN_W-1:0] cur_inc;
  logic             in_range;

  // The index never reaches the depth, so the end needs no explicit clamp.
  assign in_range = (CMP_W'(idx_i) >= CMP_W'(pos_i)) && (CMP_W'(idx_i) < CMP_W'(end_i));
  assign cur_inc  = (cur_q == RUN_MAX) ? cur_q : cur_q + RUN_W'(1);

  always_comb begin
    cur_d  = cur_q;
    best_d = best_q;
    if (ctrl_i.clear) begin
      cur_d  = '0;
      best_d = '0;
    end else if (ctrl_i.step && in_range) begin
      if (elem_i != excl_i) begin
        cur_d = cur_inc;
        if (cur_inc > best_q) begin
          best_d = cur_inc;
        end
      end else begin
        cur_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q  <= '0;
      best_q <= '0;
    end else begin
      cur_q  <= cur_d;
      best_q <= best_d;
    end
  end

  assign best_o = best_q;

endmodule

// ----- rtl/core/longest_gap_range_query_top.sv -----
// Top level of the longest gap range query block: element ring, run tracker, control.
// Depends on lgrq_pkg, lgrq_cell and lgrq_scan.

// The block stores DEPTH signed values in a ring of cells and answers queries
// for the longest run of consecutive positions in [position, range_end) whose
// value differs from excluded_value. A write transaction gives no result; the
// block is ready again in the next cycle. A query transaction rotates the
// whole ring once, one element a cycle past the run tracker, so it occupies
// the block for DEPTH rotation steps and then for the hand-over of the result
// to the output register, which waits while an earlier result is still
// stalled. The length of the ring sets how long a query occupies the block.
// The result waits in an output register, so a write may be accepted while an
// earlier result is still stalled. Entries are undefined until written; a
// query over an unwritten entry returns an unspecified count. Runs saturate
// at 2047.
module longest_gap_range_query_top import lgrq_pkg::*; #(
  parameter int unsigned DEPTH       = DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     opcode_i,
  input  logic [POS_W-1:0]         position_i,
  input  logic [END_W-1:0]         range_end_i,
  input  logic signed [DATA_W-1:0] new_value_i,
  input  logic signed [DATA_W-1:0] excluded_value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [RUN_W-1:0]         longest_run_o
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CMP_W = (IDX_W + 1 > END_W) ? IDX_W + 1 : END_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);

  lgrq_state_e state_q, state_d;

  logic                   in_fire;
  logic                   wr_fire;
  logic                   qry_fire;
  logic                   shift;
  logic                   last_step;
  logic                   out_load;

  logic [IDX_W-1:0]       idx_q, idx_d;
  logic [POS_W-1:0]       pos_q;
  logic [END_W-1:0]       end_q;
  logic [VALUE_WIDTH-1:0] excl_q;

  logic [EXT_W-1:0]       new_ext;
  logic [EXT_W-1:0]       excl_ext;
  logic [VALUE_WIDTH-1:0] wr_val;

  logic                   out_valid_q, out_valid_d;
  logic [RUN_W-1:0]       run_q;
  logic [RUN_W-1:0]       best;

  lgrq_scan_ctrl_t        scan_ctrl;

  logic [VALUE_WIDTH-1:0] cell_val [DEPTH];

  // Handshake: the input side takes a transaction only when the ring is at rest.
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign wr_fire    = in_fire && (opcode_i == OP_WRITE);
  assign qry_fire   = in_fire && (opcode_i == OP_QUERY);

  // Values are compared on their low VALUE_WIDTH bits; widen by sign first so
  // that any width up to 64 bits is covered the same way for both operands.
  assign new_ext  = {{(EXT_W - DATA_W){new_value_i[DATA_W-1]}}, new_value_i};
  assign excl_ext = {{(EXT_W - DATA_W){excluded_value_i[DATA_W-1]}}, excluded_value_i};
  assign wr_val   = new_ext[VALUE_WIDTH-1:0];

  // Element ring: cell i sits at index i while idle; during a query every cell
  // takes its upper neighbour's value, so cell 0 shows element k at step k.
  // After DEPTH steps the ring is back in its home alignment.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic wr_sel;
    assign wr_sel = wr_fire && (CMP_W'(position_i) == CMP_W'(i));

    lgrq_cell #(
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk_i    (clk_i),
      .wr_en_i  (wr_sel),
      .wr_val_i (wr_val),
      .shift_i  (shift),
      .nbr_i    (cell_val[(i + 1) % DEPTH]),
      .val_o    (cell_val[i])
    );
  end

  lgrq_scan #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .IDX_W      (IDX_W)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (scan_ctrl),
    .idx_i  (idx_q),
    .pos_i  (pos_q),
    .end_i  (end_q),
    .excl_i (excl_q),
    .elem_i (cell_val[0]),
    .best_o (best)
  );

  assign last_step = (idx_q == IDX_LAST);

  // Sequencer: next state, ring rotation and result hand-over.
  always_comb begin
    state_d         = state_q;
    idx_d           = idx_q;
    shift           = 1'b0;
    out_load        = 1'b0;
    scan_ctrl.clear = 1'b0;
    scan_ctrl.step  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (qry_fire) begin
          idx_d           = '0;
          scan_ctrl.clear = 1'b1;
          state_d         = ST_SCAN;
        end
      end
      ST_SCAN: begin
        shift          = 1'b1;
        scan_ctrl.step = 1'b1;
        idx_d          = idx_q + IDX_W'(1);
        if (last_step) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // Hold the result until the output register is free.
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Query operands: latch at acceptance, hold for the whole rotation.
  always_ff @(posedge clk_i) begin
    if (qry_fire) begin
      pos_q  <= position_i;
      end_q  <= range_end_i;
      excl_q <= excl_ext[VALUE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      run_q <= best;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign longest_run_o = run_q;

endmodule

// ----- rtl/core/lgrq_checker.sv -----
// Port-level assertions for the longest gap range query block, with its bind.
// Depends on lgrq_pkg and attaches to longest_gap_range_query_top.
module lgrq_checker import lgrq_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             opcode_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [RUN_W-1:0] longest_run_o
);

  logic in_fire;
  assign in_fire = in_valid_i && !in_stall_o;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(longest_run_o))
    else $error("stalled result changed or vanished");

  // A query occupies the block: no transaction is taken in the next cycle.
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (opcode_i == OP_QUERY) |=> in_stall_o)
    else $error("input taken right after a query");

  // A write never produces a result.
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (opcode_i == OP_WRITE) && !out_valid_o |=> !out_valid_o)
    else $error("result appeared after a write");

  // A result only appears at the end of a scan, while the input side is held.
  a_result_from_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a scan");

endmodule

bind longest_gap_range_query_top lgrq_checker u_lgrq_checker (.*);

// ----- sim/longest_gap_range_query_checker.sv -----
`timescale 1ns / 100ps
// Checker for the longest gap range query block: tracks the stored elements,
// predicts each query's longest run and compares it with the block's output.
// Depends on lgrq_pkg only.
module longest_gap_range_query_checker import lgrq_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic                     opcode_i,
  input  logic [POS_W-1:0]         position_i,
  input  logic [END_W-1:0]         range_end_i,
  input  logic signed [DATA_W-1:0] new_value_i,
  input  logic signed [DATA_W-1:0] excluded_value_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic [RUN_W-1:0]         longest_run_i,
  output int                       fail_count_o,
  output int                       pending_o,
  output int                       writes_o,
  output int                       queries_o,
  output int                       checked_o,
  output int                       longest_seen_o
);

  logic signed [DATA_W-1:0] element_mirror [DEPTH_DEF];
  logic [RUN_W-1:0]         expected_runs [$];
  logic [RUN_W-1:0]         due_run;

  initial begin
    fail_count_o   = 0;
    pending_o      = 0;
    writes_o       = 0;
    queries_o      = 0;
    checked_o      = 0;
    longest_seen_o = 0;
  end

  // Scan [first, stop) of the mirror, clamping stop to the depth.
  function automatic logic [RUN_W-1:0] longest_clear_run(
    input int unsigned              first,
    input int unsigned              stop,
    input logic signed [DATA_W-1:0] excl
  );
    int unsigned lim;
    int unsigned cur;
    int unsigned best;
    lim  = (stop > DEPTH_DEF) ? DEPTH_DEF : stop;
    cur  = 0;
    best = 0;
    for (int unsigned k = first; k < lim; k++) begin
      if (element_mirror[k] != excl) begin
        cur++;
        if (cur > best) best = cur;
      end else begin
        cur = 0;
      end
    end
    if (best > RUN_MAX) return RUN_MAX;
    return best[RUN_W-1:0];
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) begin
        if (lgrq_op_e'(opcode_i) == OP_WRITE) begin
          if (position_i < DEPTH_DEF) element_mirror[position_i] = new_value_i;
          writes_o++;
        end else begin
          expected_runs.push_back(longest_clear_run(position_i, range_end_i,
                                                    excluded_value_i));
          queries_o++;
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_runs.size() == 0) begin
          fail_count_o++;
          $display("%0t: longest_run expected none, got %0d", $time, longest_run_i);
        end else begin
          due_run = expected_runs.pop_front();
          checked_o++;
          if (int'(longest_run_i) > longest_seen_o) longest_seen_o = int'(longest_run_i);
          if (longest_run_i !== due_run) begin
            fail_count_o++;
            $display("%0t: longest_run expected %0d, got %0d",
                     $time, due_run, longest_run_i);
          end
        end
      end
      pending_o = expected_runs.size();
    end
  end

endmodule

// ----- sim/longest_gap_range_query_top_test.sv -----
`timescale 1ns / 100ps
// Testbench top for the longest gap range query block: clock, reset, stimulus
// and verdict. Depends on lgrq_pkg, the block and longest_gap_range_query_checker.
module longest_gap_range_query_top_test;
  import lgrq_pkg::*;

  typedef struct {
    lgrq_op_e                 op;
    logic [POS_W-1:0]         pos;
    logic [END_W-1:0]         range_end;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] excl;
  } gap_txn_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid;
  logic                     in_stall;
  logic                     opcode;
  logic [POS_W-1:0]         position;
  logic [END_W-1:0]         range_end;
  logic signed [DATA_W-1:0] new_value;
  logic signed [DATA_W-1:0] excluded_value;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [RUN_W-1:0]         longest_run;

  logic                     in_took;
  logic                     calm;

  int fail_count;
  int pending;
  int writes_seen;
  int queries_seen;
  int checked;
  int longest_seen;

  // Stimulus-side bookkeeping: which entries hold a written value, so that no
  // query ever scans an entry that was never written.
  bit is_written [DEPTH_DEF];
  int written_q [$];

  longest_gap_range_query_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .opcode_i         (opcode),
    .position_i       (position),
    .range_end_i      (range_end),
    .new_value_i      (new_value),
    .excluded_value_i (excluded_value),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .longest_run_o    (longest_run)
  );

  longest_gap_range_query_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .opcode_i         (opcode),
    .position_i       (position),
    .range_end_i      (range_end),
    .new_value_i      (new_value),
    .excluded_value_i (excluded_value),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .longest_run_i    (longest_run),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .writes_o         (writes_seen),
    .queries_o        (queries_seen),
    .checked_o        (checked),
    .longest_seen_o   (longest_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop: a correct run ends well before this timeout.
  initial begin
    #5_000_000;
    $display("longest_gap_range_query_top_test NOT OK");
    $finish;
  end

  // Register each input handshake so the driver can read it at the falling
  // edge without racing the block's own updates.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && !in_stall;
    end
  end

  // Receiver back-pressure: stall at random, except in the calm stretch.
  always @(negedge clk_i) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 14);
  end

  // Biased value source: extremes and a few small values recur often so that
  // excluded values really do break runs.
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      4, 5:    return $urandom_range(1, 3);
      default: return $urandom;
    endcase
  endfunction

  // First unwritten position at or after pos, or the depth.
  function automatic int contig_end(input int pos);
    int lim;
    lim = pos;
    while (lim < DEPTH_DEF && is_written[lim]) lim++;
    return lim;
  endfunction

  // Present one transaction and hold it until it is accepted. Leave valid high
  // afterwards: the next call either replaces the payload at once or idles.
  task automatic send_txn(input gap_txn_t t);
    if (!calm) begin
      while ($urandom_range(0, 99) < 14) begin
        in_valid = 1'b0;
        @(negedge clk_i);
      end
    end
    opcode         = t.op;
    position       = t.pos;
    range_end      = t.range_end;
    new_value      = t.value;
    excluded_value = t.excl;
    in_valid       = 1'b1;
    if (t.op == OP_WRITE && !is_written[t.pos]) begin
      is_written[t.pos] = 1'b1;
      written_q.push_back(int'(t.pos));
    end
    do @(negedge clk_i); while (!in_took);
  endtask

  task automatic put_write(input int pos, input logic signed [DATA_W-1:0] value);
    gap_txn_t t;
    t = '{OP_WRITE, POS_W'(pos), END_W'($urandom), value, $urandom};
    send_txn(t);
  endtask

  task automatic put_query(input int pos, input int stop,
                           input logic signed [DATA_W-1:0] excl);
    gap_txn_t t;
    t = '{OP_QUERY, POS_W'(pos), END_W'(stop), $urandom, excl};
    send_txn(t);
  endtask

  // Hold off the sender until every outstanding query has answered.
  task automatic wait_for_results();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    gap_txn_t t;
    int       base;
    int       lim;
    int       pick;
    int       guard;
    int       leftover;

    rst_ni         = 1'b0;
    in_valid       = 1'b0;
    opcode         = OP_WRITE;
    position       = '0;
    range_end      = '0;
    new_value      = '0;
    excluded_value = '0;
    calm           = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: load both ends of the store with extreme and repeating values.
    put_write(0, 32'h8000_0000);
    put_write(1, 32'h7FFF_FFFF);
    put_write(2, 32'h0000_0000);
    put_write(3, 32'hFFFF_FFFF);
    put_write(4, 32'h5555_5555);
    put_write(5, 32'hAAAA_AAAA);
    put_write(6, 32'hFFFF_FFFF);
    put_write(7, 32'h0000_0000);
    put_write(1020, 7);
    put_write(1021, 32'hFFFF_FFFF);
    put_write(1022, 7);
    put_write(1023, 7);

    put_query(0, 8, 32'hFFFF_FFFF);     // runs split by all-ones
    put_query(0, 8, 32'h0000_1234);     // nothing excluded: whole range
    put_query(0, 8, 32'h0000_0000);     // runs split by zero
    put_query(3, 4, 32'h7FFF_FFFF);     // one element, not excluded
    put_query(1020, 2047, 7);           // end far past the depth, clamped
    put_query(1020, 1024, 32'h8000_0000);
    put_query(1023, 1024, 7);           // one element, excluded
    put_query(5, 5, 32'h0000_0000);     // empty range: end equals start
    put_query(1023, 0, 32'hFFFF_FFFF);  // end below start
    wait_for_results();

    // Random: mostly grow contiguous written regions and query inside them,
    // with scattered writes and overwrites as noise.
    for (int n = 0; n < 560; n++) begin
      calm = (n >= 240 && n < 330);
      if (n % 140 == 139) wait_for_results();
      if ($urandom_range(0, 99) < 58) begin
        t.op        = OP_WRITE;
        t.range_end = END_W'($urandom);
        t.excl      = $urandom;
        t.value     = pick_value();
        pick        = $urandom_range(0, 9);
        base        = written_q[$urandom_range(0, written_q.size() - 1)];
        if (pick < 5) begin
          lim   = contig_end(base);
          t.pos = POS_W'((lim < DEPTH_DEF) ? lim : $urandom_range(0, DEPTH_DEF - 1));
        end else if (pick < 8) begin
          t.pos = POS_W'($urandom_range(0, DEPTH_DEF - 1));
        end else begin
          t.pos = POS_W'(base);
        end
      end else begin
        t.op    = OP_QUERY;
        t.value = $urandom;
        t.excl  = ($urandom_range(0, 3) != 0) ? pick_value() : $urandom;
        base    = written_q[$urandom_range(0, written_q.size() - 1)];
        lim     = contig_end(base);
        pick    = $urandom_range(0, 9);
        t.pos   = POS_W'(base);
        if (pick == 0) begin
          t.range_end = END_W'($urandom_range(0, base));
        end else if (lim == DEPTH_DEF && pick < 4) begin
          t.range_end = END_W'($urandom_range(DEPTH_DEF, 2047));
        end else if (pick >= 6) begin
          t.range_end = END_W'(lim);
        end else begin
          t.range_end = END_W'($urandom_range(base + 1, lim));
        end
      end
      send_txn(t);
    end
    in_valid = 1'b0;
    calm     = 1'b0;

    // Drain: wait for the last answers, then keep watching for strays.
    for (guard = 0; guard < 4000 && pending != 0; guard++) @(negedge clk_i);
    repeat (DEPTH_DEF + 8) @(negedge clk_i);
    leftover = pending;
    if (leftover != 0) begin
      $display("%0t: %0d longest_run results expected, none arrived", $time, leftover);
    end

    $display("Run covered %0d writes and %0d queries over %0d stored positions;",
             writes_seen, queries_seen, written_q.size());
    $display("%0d results compared, longest run returned %0d.", checked, longest_seen);
    if (fail_count == 0 && leftover == 0) begin
      $display("longest_gap_range_query_top_test OK");
    end else begin
      $display("longest_gap_range_query_top_test NOT OK");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/lgrq_pkg.sv
rtl/core/lgrq_cell.sv
rtl/core/lgrq_scan.sv
rtl/core/longest_gap_range_query_top.sv
rtl/core/lgrq_checker.sv
sim/longest_gap_range_query_checker.sv
sim/longest_gap_range_query_top_test.sv
